[hdl/dmb_pkg.sv]
// Shared types, constants and helper functions of the decimal Morse blinker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package dmb_pkg;

  // Largest number of decimal digits that a value is written with.
  localparam int unsigned MaxDigits = 5;

  // Reset values of the two duration registers, in milliseconds.
  localparam logic [15:0] ShortMsReset = 16'd100;
  localparam logic [15:0] LongMsReset  = 16'd300;

  // Register indexes of the configuration port.
  localparam logic CfgShortMs = 1'b0;
  localparam logic CfgLongMs  = 1'b1;

  // Digit queue between front and back; the depth must be a power of two.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // Binary to BCD conversion shifts one input bit per cycle.
  localparam int unsigned ValueW = 32;
  localparam int unsigned ConvCntW = $clog2(ValueW);

  // Each digit gives ten segments: five elements, each followed by a gap.
  localparam logic [3:0] SegFinal = 4'd9;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CONV,
    FS_EMIT
  } front_state_e;

  typedef struct packed {
    logic [3:0] digit;
    logic       last;
  } entry_t;

  // Largest value with n decimal digits, evaluated at elaboration only.
  function automatic logic [33:0] max_value(int unsigned n);
    logic [33:0] v;
    v = 34'd1;
    for (int unsigned i = 0; i < n; i++) begin
      v = v * 34'd10;
    end
    return v - 34'd1;
  endfunction

  // True when element pos (0..4) of the Morse pattern of digit d is a dash.
  function automatic logic elem_is_dash(logic [3:0] d, logic [2:0] pos);
    logic res;
    if (d == 4'd0) begin
      res = 1'b1;
    end else if (d <= 4'd5) begin
      res = ({1'b0, pos} >= d);
    end else begin
      res = ({1'b0, pos} < (d - 4'd5));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/dmb_front.sv]
// Front end: accepts a number, clamps it, converts it to BCD by shift-and-add-3
// and pushes its digits, leading zeros dropped, into the digit queue. Uses dmb_pkg.
`default_nettype none

module dmb_front #(
  parameter int unsigned MAX_DIGITS = dmb_pkg::MaxDigits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dmb_pkg::ValueW-1:0]    value_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output dmb_pkg::entry_t                    q_entry_o
);
  import dmb_pkg::*;

  localparam int unsigned BcdW = 4 * MAX_DIGITS;
  localparam int unsigned IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [33:0] Limit = max_value(MAX_DIGITS);

  front_state_e        state_q, state_d;
  logic [ValueW-1:0]   sh_q, sh_d;
  logic [BcdW-1:0]     bcd_q, bcd_d, bcd_adj;
  logic [ConvCntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                started_q, started_d;
  logic [ValueW-1:0]   clamped;
  logic [3:0]          cur_digit;
  logic                is_lead;
  logic                in_xfer;
  logic                conv_done;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign conv_done = (cnt_q == ConvCntW'(ValueW - 1));
  assign clamped   = ({2'b00, value_i} > Limit) ? Limit[ValueW-1:0] : value_i;
  assign cur_digit = bcd_q[idx_q * 4 +: 4];
  // A zero ahead of the first nonzero digit is skipped, but never the units digit.
  assign is_lead   = (cur_digit == 4'd0) && !started_q && (idx_q != '0);

  always_comb begin
    for (int unsigned i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[i * 4 +: 4] = (bcd_q[i * 4 +: 4] >= 4'd5) ? bcd_q[i * 4 +: 4] + 4'd3
                                                         : bcd_q[i * 4 +: 4];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: if (in_valid_i) state_d = FS_CONV;
      FS_CONV: if (conv_done) state_d = FS_EMIT;
      FS_EMIT: if (q_push_o && (idx_q == '0)) state_d = FS_IDLE;
      default: state_d = FS_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o = 1'b0;
    q_push_o   = 1'b0;
    unique case (state_q)
      FS_IDLE: in_ready_o = 1'b1;
      FS_CONV: ;
      FS_EMIT: q_push_o = !is_lead && !q_full_i;
      default: ;
    endcase
    q_entry_o.digit = cur_digit;
    q_entry_o.last  = (idx_q == '0);
  end

  // Datapath.
  always_comb begin
    sh_d      = sh_q;
    bcd_d     = bcd_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    started_d = started_q;
    if (in_xfer) begin
      sh_d  = clamped;
      bcd_d = '0;
      cnt_d = '0;
    end else if (state_q == FS_CONV) begin
      sh_d  = {sh_q[ValueW-2:0], 1'b0};
      bcd_d = {bcd_adj[BcdW-2:0], sh_q[ValueW-1]};
      cnt_d = cnt_q + ConvCntW'(1);
      if (conv_done) begin
        idx_d     = IdxW'(MAX_DIGITS - 1);
        started_d = 1'b0;
      end
    end else if (state_q == FS_EMIT) begin
      if (q_push_o) begin
        started_d = 1'b1;
      end
      if ((q_push_o || is_lead) && (idx_q != '0)) begin
        idx_d = idx_q - IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q      <= sh_d;
    bcd_q     <= bcd_d;
    cnt_q     <= cnt_d;
    idx_q     <= idx_d;
    started_q <= started_d;
  end

endmodule

`default_nettype wire

[hdl/dmb_queue.sv]
// Short digit queue between the front and back ends of the blinker.
// Register-based FIFO with first-word fall-through; uses dmb_pkg.
`default_nettype none

module dmb_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire dmb_pkg::entry_t entry_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output dmb_pkg::entry_t      head_o
);
  import dmb_pkg::*;

  entry_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;

  assign full_o  = (count_q == (QueuePtrW + 1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QueuePtrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QueuePtrW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("digit queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("digit queue read while empty");
`endif

endmodule

`default_nettype wire

[hdl/dmb_back.sv]
// Back end: takes one digit at a time from the queue and plays out its ten
// Morse segments on the result channel. Uses dmb_pkg.
`default_nettype none

module dmb_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  wire dmb_pkg::entry_t q_head_i,
  output logic                 q_pop_o,
  input  wire logic [15:0]     short_ms_i,
  input  wire logic [15:0]     long_ms_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 led_on_o,
  output logic [15:0]          duration_o,
  output logic                 last_o
);
  import dmb_pkg::*;

  logic       busy_q;
  logic [3:0] seg_q;
  entry_t     ent_q;
  logic       out_xfer;
  logic       seg_end;
  logic       dash;

  assign out_valid_o = busy_q;
  assign out_xfer    = busy_q && out_ready_i;
  assign seg_end     = (seg_q == SegFinal);
  // The next digit is loaded in the cycle the last segment of this one transfers.
  assign q_pop_o     = !q_empty_i && (!busy_q || (out_xfer && seg_end));

  // Even segments are elements (light on), odd segments are gaps.
  assign dash       = elem_is_dash(ent_q.digit, seg_q[3:1]);
  assign led_on_o   = !seg_q[0];
  assign duration_o = seg_q[0] ? (seg_end ? long_ms_i : short_ms_i)
                               : (dash ? long_ms_i : short_ms_i);
  assign last_o     = seg_end && ent_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      seg_q  <= '0;
    end else if (q_pop_o) begin
      busy_q <= 1'b1;
      seg_q  <= '0;
    end else if (out_xfer && seg_end) begin
      busy_q <= 1'b0;
    end else if (out_xfer) begin
      seg_q <= seg_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ent_q <= q_head_i;
    end
  end

`ifndef SYNTH
  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (seg_q <= SegFinal))
    else $error("segment counter out of range");

  a_digit_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !(out_xfer && seg_end)) |=> ($stable(ent_q) && busy_q))
    else $error("digit changed before its last segment transferred");
`endif

endmodule

`default_nettype wire

[hdl/decimal_morse_blinker.sv]
// Decimal Morse blinker, top level: configuration registers, front end,
// digit queue and back end. Depends on dmb_pkg, dmb_front, dmb_queue, dmb_back.
//
// Usage: a number is transferred on the input channel (in_valid_i/in_ready_o,
// value_i). It is clamped to 10^MAX_DIGITS - 1 and written in decimal without
// leading zeros; zero is sent as the digit 0. Each digit gives ten segments on
// the output channel (out_valid_o/out_ready_i, led_on_o, duration_o, last_o),
// most significant digit first; last_o marks the final segment of the number.
// Durations come from register 0 (short, reset 100) and register 1 (long,
// reset 300) on cfg_we_i/cfg_idx_i/cfg_data_i; write them only while the block
// is idle, which the block itself does not enforce. After an input transfer the
// front end converts the number to BCD, skips leading zeros and pushes each digit
// into the queue; the back end loads the head digit into its segment register.
// The front end accepts the next number once its last digit is pushed, while
// earlier digits still play out. The back end gives one segment per ready cycle
// while digits wait in the queue. When the receiver stalls the segment holds, the
// queue of four digits fills and then the front end and the input channel wait.
// Reset empties the queue, drops any number in progress and restores the register
// defaults.
`default_nettype none

module decimal_morse_blinker #(
  parameter int unsigned MAX_DIGITS = dmb_pkg::MaxDigits
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [dmb_pkg::ValueW-1:0] value_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            led_on_o,
  output logic [15:0]                     duration_o,
  output logic                            last_o,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [15:0]                cfg_data_i
);
  import dmb_pkg::*;

  logic [15:0] short_ms_q;
  logic [15:0] long_ms_q;
  logic        q_push, q_pop, q_full, q_empty;
  entry_t      q_entry, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_ms_q <= ShortMsReset;
      long_ms_q  <= LongMsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgShortMs: short_ms_q <= cfg_data_i;
        CfgLongMs:  long_ms_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dmb_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .value_i   (value_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_entry)
  );

  dmb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .head_o (q_head)
  );

  dmb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .short_ms_i (short_ms_q),
    .long_ms_i  (long_ms_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .led_on_o   (led_on_o),
    .duration_o (duration_o),
    .last_o     (last_o)
  );

`ifndef SYNTH
  a_last_is_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (!led_on_o && (duration_o == long_ms_q)))
    else $error("final segment is not a long off gap");
`endif

endmodule

`default_nettype wire
